/* rtl/smp_pkg.sv */
package smp_pkg;

  localparam int MAX_CONSTRAINTS = 16;
  localparam int MAX_VARIABLES   = 16;
  localparam int ROWS            = MAX_CONSTRAINTS + 1;
  localparam int COLS            = MAX_CONSTRAINTS + MAX_VARIABLES + 1;
  localparam int CELLS           = ROWS * COLS;
  localparam int ADDR_W          = $clog2(CELLS);
  localparam int ROW_W           = $clog2(ROWS);
  localparam int COL_W           = $clog2(COLS);
  localparam int PIVOT_LIMIT     = 512;
  localparam int CNT_W           = $clog2(PIVOT_LIMIT);
  localparam int SIZE_W          = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_LOAD_C = 2'd2;
  localparam logic [1:0] ACT_SOLVE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CONSTRAINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARIABLES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_RULE      = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [63:0] coefficient;
  } in_req_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] objective;
    logic               saturated;
  } out_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        sat;
  } md_rsp_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] rr;
    rr = ADDR_W'(r);
    return ADDR_W'(rr * ADDR_W'(COLS)) + ADDR_W'(c);
  endfunction

endpackage

/* rtl/smp_muldiv.sv */
module smp_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  smp_pkg::md_req_t  req,
  output smp_pkg::md_rsp_t  rsp
);

  localparam logic [2:0] MD_IDLE = 3'd0;
  localparam logic [2:0] MD_MUL  = 3'd1;
  localparam logic [2:0] MD_CHK  = 3'd2;
  localparam logic [2:0] MD_DIV  = 3'd3;
  localparam logic [2:0] MD_FIN  = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [5:0]   step_r, step_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic         neg_r, neg_nxt, xyneg_r, xyneg_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  rem_r, rem_nxt, quo_r, quo_nxt;
  smp_pkg::md_rsp_t rsp_r, rsp_nxt;

  logic [31:0]  mul_a, mul_b;
  logic [127:0] pp_sh;
  logic [63:0]  r2;
  logic         take;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  assign rsp = rsp_r;

  always_comb begin
    mul_a = step_r[1] ? a_r[63:32] : a_r[31:0];
    mul_b = step_r[0] ? b_r[63:32] : b_r[31:0];
    case (step_r[1:0] - 2'd1)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      2'd2:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
    r2   = {rem_r[62:0], quo_r[63]};
    take = rem_r[63] || (r2 >= d_r);
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    neg_nxt   = neg_r;
    xyneg_nxt = xyneg_r;
    pp_nxt    = pp_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    rsp_nxt   = rsp_r;
    rsp_nxt.done = 1'b0;
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt     = mag(req.x);
          b_nxt     = mag(req.y);
          d_nxt     = mag(req.z);
          xyneg_nxt = req.x[63] ^ req.y[63];
          neg_nxt   = req.x[63] ^ req.y[63] ^ req.z[63];
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        if (step_r < 6'd4) begin
          pp_nxt = 64'(mul_a * mul_b);
        end
        if (step_r != 6'd0) begin
          acc_nxt = acc_r + pp_sh;
        end
        if (step_r == 6'd4) begin
          state_nxt = MD_CHK;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      MD_CHK: begin
        if (d_r == 64'd0) begin
          rsp_nxt.done = 1'b1;
          rsp_nxt.sat  = 1'b1;
          if (a_r == 64'd0 || b_r == 64'd0) begin
            rsp_nxt.res = 64'd0;
          end else begin
            rsp_nxt.res = xyneg_r ? smp_pkg::Q_MIN : smp_pkg::Q_MAX;
          end
          state_nxt = MD_IDLE;
        end else if (acc_r[127:64] >= d_r) begin
          rsp_nxt.done = 1'b1;
          rsp_nxt.sat  = 1'b1;
          rsp_nxt.res  = neg_r ? smp_pkg::Q_MIN : smp_pkg::Q_MAX;
          state_nxt    = MD_IDLE;
        end else begin
          rem_nxt   = acc_r[127:64];
          quo_nxt   = acc_r[63:0];
          step_nxt  = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt = take ? (r2 - d_r) : r2;
        quo_nxt = {quo_r[62:0], take};
        if (step_r == 6'd63) begin
          state_nxt = MD_FIN;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      MD_FIN: begin
        rsp_nxt.done = 1'b1;
        if (neg_r) begin
          rsp_nxt.sat = quo_r > smp_pkg::Q_MIN;
          rsp_nxt.res = (quo_r > smp_pkg::Q_MIN) ? smp_pkg::Q_MIN : (64'd0 - quo_r);
        end else begin
          rsp_nxt.sat = quo_r[63];
          rsp_nxt.res = quo_r[63] ? smp_pkg::Q_MAX : quo_r;
        end
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= MD_IDLE;
      rsp_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rsp_r    <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    d_r     <= d_nxt;
    neg_r   <= neg_nxt;
    xyneg_r <= xyneg_nxt;
    pp_r    <= pp_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

endmodule

/* rtl/simplex_lp_solver_unit.sv */
// Load requests: accepted one per cycle while idle, written to the tableau RAM directly.
// Solve request: each pivot runs its ratio test, row elimination and pivot-row scaling through
// the shared multiply/divide unit; up to 512 pivots, plus a final column scan.
// One result per solve, held in an output register; loads proceed while it waits.
// Reset (sync, active low) and any size register write start a tableau clear pass over all
// 561 cells; no request is accepted during it.
module simplex_lp_solver_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smp_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smp_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [smp_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [smp_pkg::SIZE_W-1:0]          cfg_wdata
);

  localparam int AW = smp_pkg::ADDR_W;
  localparam int RW = smp_pkg::ROW_W;
  localparam int CW = smp_pkg::COL_W;
  localparam int SW = smp_pkg::SIZE_W;
  localparam int NW = smp_pkg::CNT_W;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_EN_RD   = 5'd2;
  localparam logic [4:0] S_EN_EV   = 5'd3;
  localparam logic [4:0] S_EN_DEC  = 5'd4;
  localparam logic [4:0] S_LV_RQ   = 5'd5;
  localparam logic [4:0] S_LV_RW   = 5'd6;
  localparam logic [4:0] S_LV_CK   = 5'd7;
  localparam logic [4:0] S_LV_WT   = 5'd8;
  localparam logic [4:0] S_LV_NX   = 5'd9;
  localparam logic [4:0] S_PV_RD   = 5'd10;
  localparam logic [4:0] S_PV_GET  = 5'd11;
  localparam logic [4:0] S_RW_ST   = 5'd12;
  localparam logic [4:0] S_RW_FAC  = 5'd13;
  localparam logic [4:0] S_EL_RP   = 5'd14;
  localparam logic [4:0] S_EL_RI   = 5'd15;
  localparam logic [4:0] S_EL_MD   = 5'd16;
  localparam logic [4:0] S_EL_WT   = 5'd17;
  localparam logic [4:0] S_EL_NX   = 5'd18;
  localparam logic [4:0] S_RW_ZQ   = 5'd19;
  localparam logic [4:0] S_RW_NX   = 5'd20;
  localparam logic [4:0] S_PR_RD   = 5'd21;
  localparam logic [4:0] S_PR_MD   = 5'd22;
  localparam logic [4:0] S_PR_WT   = 5'd23;
  localparam logic [4:0] S_PR_NX   = 5'd24;
  localparam logic [4:0] S_PR_ONE  = 5'd25;
  localparam logic [4:0] S_DONE_RD = 5'd26;
  localparam logic [4:0] S_DONE_EV = 5'd27;

  logic [63:0] tab_mem [smp_pkg::CELLS];
  logic [63:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [63:0] wdata;
  logic        we;

  logic [4:0]    state_r, state_nxt;
  logic [SW-1:0] m_cfg_r, m_cfg_nxt, n_cfg_r, n_cfg_nxt;
  logic          rule_r, rule_nxt;
  logic [RW-1:0] clr_row_r, clr_row_nxt;
  logic [CW-1:0] clr_col_r, clr_col_nxt;
  logic [RW-1:0] i_r, i_nxt, p_r, p_nxt;
  logic [CW-1:0] j_r, j_nxt, q_r, q_nxt, bq_r, bq_nxt, dq_r, dq_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          found_r, found_nxt, lvf_r, lvf_nxt;
  logic          sat_r, sat_nxt, status_r, status_nxt, out_valid_r, out_valid_nxt;
  logic [63:0]   best_r, best_nxt, lvbest_r, lvbest_nxt, pv_r, pv_nxt;
  logic [63:0]   fac_r, fac_nxt, pj_r, pj_nxt, aij_r, aij_nxt, colv_r, colv_nxt;
  smp_pkg::out_req_t out_data_r, out_data_nxt;

  smp_pkg::md_req_t md_req;
  smp_pkg::md_rsp_t md_rsp;

  logic [RW-1:0] m_eff;
  logic [CW-1:0] n_eff, w_eff;
  logic [64:0]   diff;
  logic          diff_ovf;
  logic [63:0]   sub_val;

  smp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  always_comb begin
    if (m_cfg_r == '0) begin
      m_eff = RW'(1);
    end else if (m_cfg_r > SW'(smp_pkg::MAX_CONSTRAINTS)) begin
      m_eff = RW'(smp_pkg::MAX_CONSTRAINTS);
    end else begin
      m_eff = RW'(m_cfg_r);
    end
    if (n_cfg_r == '0) begin
      n_eff = CW'(1);
    end else if (n_cfg_r > SW'(smp_pkg::MAX_VARIABLES)) begin
      n_eff = CW'(smp_pkg::MAX_VARIABLES);
    end else begin
      n_eff = CW'(n_cfg_r);
    end
    w_eff    = CW'(m_eff) + n_eff;
    diff     = {aij_r[63], aij_r} - {md_rsp.res[63], md_rsp.res};
    diff_ovf = diff[64] ^ diff[63];
    sub_val  = diff_ovf ? (diff[64] ? smp_pkg::Q_MIN : smp_pkg::Q_MAX) : diff[63:0];
  end

  always_comb begin
    state_nxt     = state_r;
    m_cfg_nxt     = m_cfg_r;
    n_cfg_nxt     = n_cfg_r;
    rule_nxt      = rule_r;
    clr_row_nxt   = clr_row_r;
    clr_col_nxt   = clr_col_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    bq_nxt        = bq_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    lvf_nxt       = lvf_r;
    sat_nxt       = sat_r;
    status_nxt    = status_r;
    best_nxt      = best_r;
    lvbest_nxt    = lvbest_r;
    pv_nxt        = pv_r;
    fac_nxt       = fac_r;
    pj_nxt        = pj_r;
    aij_nxt       = aij_r;
    colv_nxt      = colv_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    md_req        = '0;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = smp_pkg::cell_addr(clr_row_r, clr_col_r);
        wdata = ((clr_row_r < m_eff) && (clr_col_r == n_eff + CW'(clr_row_r)))
                ? smp_pkg::Q_ONE : 64'd0;
        if (clr_col_r == CW'(smp_pkg::COLS - 1)) begin
          clr_col_nxt = '0;
          if (clr_row_r == RW'(smp_pkg::ROWS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            clr_row_nxt = clr_row_r + RW'(1);
          end
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.action)
            smp_pkg::ACT_LOAD_A: begin
              we    = (RW'(in_data.row_index) < m_eff) && (CW'(in_data.col_index) < n_eff);
              waddr = smp_pkg::cell_addr(RW'(in_data.row_index), CW'(in_data.col_index));
              wdata = in_data.coefficient;
            end
            smp_pkg::ACT_LOAD_B: begin
              we    = RW'(in_data.row_index) < m_eff;
              waddr = smp_pkg::cell_addr(RW'(in_data.row_index), w_eff);
              wdata = in_data.coefficient;
            end
            smp_pkg::ACT_LOAD_C: begin
              we    = CW'(in_data.col_index) < n_eff;
              waddr = smp_pkg::cell_addr(m_eff, CW'(in_data.col_index));
              wdata = in_data.coefficient;
            end
            default: begin
              sat_nxt    = 1'b0;
              status_nxt = 1'b0;
              cnt_nxt    = '0;
              j_nxt      = '0;
              found_nxt  = 1'b0;
              state_nxt  = S_EN_RD;
            end
          endcase
        end
      end
      S_EN_RD: begin
        raddr     = smp_pkg::cell_addr(m_eff, j_r);
        state_nxt = S_EN_EV;
      end
      S_EN_EV: begin
        if (!found_r && $signed(rdata_r) > 0) begin
          found_nxt = 1'b1;
          bq_nxt    = j_r;
        end
        if (j_r == '0 || $signed(rdata_r) > $signed(best_r)) begin
          best_nxt = rdata_r;
          dq_nxt   = j_r;
        end
        if (j_r == w_eff - CW'(1)) begin
          state_nxt = S_EN_DEC;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_EN_RD;
        end
      end
      S_EN_DEC: begin
        i_nxt   = '0;
        lvf_nxt = 1'b0;
        if (rule_r) begin
          q_nxt     = dq_r;
          state_nxt = ($signed(best_r) > 0) ? S_LV_RQ : S_DONE_RD;
        end else begin
          q_nxt     = bq_r;
          state_nxt = found_r ? S_LV_RQ : S_DONE_RD;
        end
      end
      S_LV_RQ: begin
        raddr     = smp_pkg::cell_addr(i_r, q_r);
        state_nxt = S_LV_RW;
      end
      S_LV_RW: begin
        raddr     = smp_pkg::cell_addr(i_r, w_eff);
        colv_nxt  = rdata_r;
        state_nxt = S_LV_CK;
      end
      S_LV_CK: begin
        if ($signed(colv_r) > 0) begin
          md_req.start = 1'b1;
          md_req.x     = rdata_r;
          md_req.y     = smp_pkg::Q_ONE;
          md_req.z     = colv_r;
          state_nxt    = S_LV_WT;
        end else begin
          state_nxt = S_LV_NX;
        end
      end
      S_LV_WT: begin
        if (md_rsp.done) begin
          sat_nxt = sat_r | md_rsp.sat;
          if (!lvf_r || $signed(md_rsp.res) < $signed(lvbest_r)) begin
            lvf_nxt    = 1'b1;
            lvbest_nxt = md_rsp.res;
            p_nxt      = i_r;
          end
          state_nxt = S_LV_NX;
        end
      end
      S_LV_NX: begin
        if (i_r == m_eff - RW'(1)) begin
          if (!lvf_r) begin
            status_nxt = 1'b1;
            state_nxt  = S_DONE_RD;
          end else begin
            state_nxt = S_PV_RD;
          end
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_LV_RQ;
        end
      end
      S_PV_RD: begin
        raddr     = smp_pkg::cell_addr(p_r, q_r);
        state_nxt = S_PV_GET;
      end
      S_PV_GET: begin
        pv_nxt    = rdata_r;
        i_nxt     = '0;
        state_nxt = S_RW_ST;
      end
      S_RW_ST: begin
        if (i_r == p_r) begin
          state_nxt = S_RW_NX;
        end else begin
          raddr     = smp_pkg::cell_addr(i_r, q_r);
          state_nxt = S_RW_FAC;
        end
      end
      S_RW_FAC: begin
        fac_nxt   = rdata_r;
        j_nxt     = '0;
        state_nxt = S_EL_RP;
      end
      S_EL_RP: begin
        if (j_r == q_r) begin
          state_nxt = S_EL_NX;
        end else begin
          raddr     = smp_pkg::cell_addr(p_r, j_r);
          state_nxt = S_EL_RI;
        end
      end
      S_EL_RI: begin
        pj_nxt    = rdata_r;
        raddr     = smp_pkg::cell_addr(i_r, j_r);
        state_nxt = S_EL_MD;
      end
      S_EL_MD: begin
        aij_nxt      = rdata_r;
        md_req.start = 1'b1;
        md_req.x     = pj_r;
        md_req.y     = fac_r;
        md_req.z     = pv_r;
        state_nxt    = S_EL_WT;
      end
      S_EL_WT: begin
        if (md_rsp.done) begin
          we        = 1'b1;
          waddr     = smp_pkg::cell_addr(i_r, j_r);
          wdata     = sub_val;
          sat_nxt   = sat_r | md_rsp.sat | diff_ovf;
          state_nxt = S_EL_NX;
        end
      end
      S_EL_NX: begin
        if (j_r == w_eff) begin
          state_nxt = S_RW_ZQ;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_EL_RP;
        end
      end
      S_RW_ZQ: begin
        we        = 1'b1;
        waddr     = smp_pkg::cell_addr(i_r, q_r);
        wdata     = 64'd0;
        state_nxt = S_RW_NX;
      end
      S_RW_NX: begin
        if (i_r == m_eff) begin
          j_nxt     = '0;
          state_nxt = S_PR_RD;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_RW_ST;
        end
      end
      S_PR_RD: begin
        if (j_r == q_r) begin
          state_nxt = S_PR_NX;
        end else begin
          raddr     = smp_pkg::cell_addr(p_r, j_r);
          state_nxt = S_PR_MD;
        end
      end
      S_PR_MD: begin
        md_req.start = 1'b1;
        md_req.x     = rdata_r;
        md_req.y     = smp_pkg::Q_ONE;
        md_req.z     = pv_r;
        state_nxt    = S_PR_WT;
      end
      S_PR_WT: begin
        if (md_rsp.done) begin
          we        = 1'b1;
          waddr     = smp_pkg::cell_addr(p_r, j_r);
          wdata     = md_rsp.res;
          sat_nxt   = sat_r | md_rsp.sat;
          state_nxt = S_PR_NX;
        end
      end
      S_PR_NX: begin
        if (j_r == w_eff) begin
          state_nxt = S_PR_ONE;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_PR_RD;
        end
      end
      S_PR_ONE: begin
        we        = 1'b1;
        waddr     = smp_pkg::cell_addr(p_r, q_r);
        wdata     = smp_pkg::Q_ONE;
        j_nxt     = '0;
        found_nxt = 1'b0;
        if (cnt_r == NW'(smp_pkg::PIVOT_LIMIT - 1)) begin
          state_nxt = S_DONE_RD;
        end else begin
          cnt_nxt   = cnt_r + NW'(1);
          state_nxt = S_EN_RD;
        end
      end
      S_DONE_RD: begin
        raddr     = smp_pkg::cell_addr(m_eff, w_eff);
        state_nxt = S_DONE_EV;
      end
      S_DONE_EV: begin
        raddr = smp_pkg::cell_addr(m_eff, w_eff);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.objective = (rdata_r == smp_pkg::Q_MIN) ? smp_pkg::Q_MAX
                                                               : (64'd0 - rdata_r);
          out_data_nxt.saturated = sat_r | (rdata_r == smp_pkg::Q_MIN);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        smp_pkg::CFG_NUM_CONSTRAINTS: begin
          m_cfg_nxt   = cfg_wdata;
          clr_row_nxt = '0;
          clr_col_nxt = '0;
          state_nxt   = S_CLR;
        end
        smp_pkg::CFG_NUM_VARIABLES: begin
          n_cfg_nxt   = cfg_wdata;
          clr_row_nxt = '0;
          clr_col_nxt = '0;
          state_nxt   = S_CLR;
        end
        smp_pkg::CFG_PIVOT_RULE: begin
          rule_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tab_mem[waddr] <= wdata;
    end
    rdata_r <= tab_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      m_cfg_r     <= SW'(1);
      n_cfg_r     <= SW'(1);
      rule_r      <= 1'b0;
      clr_row_r   <= '0;
      clr_col_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      m_cfg_r     <= m_cfg_nxt;
      n_cfg_r     <= n_cfg_nxt;
      rule_r      <= rule_nxt;
      clr_row_r   <= clr_row_nxt;
      clr_col_r   <= clr_col_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    bq_r       <= bq_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    lvf_r      <= lvf_nxt;
    status_r   <= status_nxt;
    best_r     <= best_nxt;
    lvbest_r   <= lvbest_nxt;
    pv_r       <= pv_nxt;
    fac_r      <= fac_nxt;
    pj_r       <= pj_nxt;
    aij_r      <= aij_nxt;
    colv_r     <= colv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/smp_chk.sv */
module smp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input smp_pkg::out_req_t             out_data,
  input logic                          cfg_we,
  input logic [smp_pkg::CFG_IDX_W-1:0] cfg_idx
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during clear after reset");

  a_size_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == smp_pkg::CFG_NUM_CONSTRAINTS ||
               cfg_idx == smp_pkg::CFG_NUM_VARIABLES) |=> !in_ready)
    else $error("request taken during clear after size write");

endmodule

bind simplex_lp_solver_unit smp_chk u_smp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx)
);

/* dv/tb_simplex_lp_solver_unit.sv */
module tb_simplex_lp_solver_unit;

  localparam logic [smp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint LP_ONE = 64'sh0000_0001_0000_0000;
  localparam longint LP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LP_MIN = 64'sh8000_0000_0000_0000;
  localparam int LONG_HOLD = 50_000;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int TARGET_REQS = 1950;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  smp_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  smp_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [smp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [smp_pkg::SIZE_W-1:0] cfg_wdata = '0;

  simplex_lp_solver_unit dut (.*);

  always #6 clk = ~clk;

  // tableau shadow and its settings
  longint lp_tab [0:smp_pkg::ROWS-1][0:smp_pkg::COLS-1];
  logic [4:0] rows_reg = 5'd1;
  logic [4:0] vars_reg = 5'd1;
  logic dantzig = 1'b0;
  bit sat_seen;

  smp_pkg::out_req_t solve_q[$];
  int errors = 0;
  int sent = 0;
  int solves_done = 0;
  int unbounded_seen = 0;
  int sat_results = 0;
  int cyc = 0;
  bit calm = 0;
  bit long_req = 0;
  int hold = 0;

  function automatic int rows_used();
    return rows_reg < 1 ? 1 : (rows_reg > smp_pkg::MAX_CONSTRAINTS ? smp_pkg::MAX_CONSTRAINTS
                                                                     : int'(rows_reg));
  endfunction

  function automatic int vars_used();
    return vars_reg < 1 ? 1 : (vars_reg > smp_pkg::MAX_VARIABLES ? smp_pkg::MAX_VARIABLES
                                                                   : int'(vars_reg));
  endfunction

  function automatic void clear_tab();
    int m, n;
    m = rows_used();
    n = vars_used();
    foreach (lp_tab[i, j]) lp_tab[i][j] = 0;
    for (int i = 0; i < m; i++) lp_tab[i][n + i] = LP_ONE;
  endfunction

  // trunc(x*y/z) with saturation
  function automatic longint scale_div(longint x, longint y, longint z);
    logic signed [127:0] p, d, qt;
    if (z == 0) begin
      sat_seen = 1;
      if (x == 0 || y == 0) return 0;
      return ((x < 0) != (y < 0)) ? LP_MIN : LP_MAX;
    end
    p = x;
    d = y;
    p = p * d;
    d = z;
    qt = p / d;
    if (qt > LP_MAX) begin
      sat_seen = 1;
      return LP_MAX;
    end
    if (qt < LP_MIN) begin
      sat_seen = 1;
      return LP_MIN;
    end
    return longint'(qt);
  endfunction

  function automatic longint sub_clip(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > LP_MAX) begin
      sat_seen = 1;
      return LP_MAX;
    end
    if (s < LP_MIN) begin
      sat_seen = 1;
      return LP_MIN;
    end
    return longint'(s);
  endfunction

  function automatic smp_pkg::out_req_t run_solve();
    smp_pkg::out_req_t r;
    int m, w, p, q;
    longint best, ratio, piv, corner;
    m = rows_used();
    w = m + vars_used();
    r = '0;
    sat_seen = 0;
    for (int k = 0; k < smp_pkg::PIVOT_LIMIT; k++) begin
      q = -1;
      if (!dantzig) begin
        for (int j = 0; j < w; j++)
          if (q < 0 && lp_tab[m][j] > 0) q = j;
      end else begin
        q = 0;
        for (int j = 1; j < w; j++) if (lp_tab[m][j] > lp_tab[m][q]) q = j;
        if (lp_tab[m][q] <= 0) q = -1;
      end
      if (q < 0) break;
      p = -1;
      best = 0;
      for (int i = 0; i < m; i++) begin
        if (lp_tab[i][q] > 0) begin
          ratio = scale_div(lp_tab[i][w], LP_ONE, lp_tab[i][q]);
          if (p == -1 || ratio < best) begin
            p = i;
            best = ratio;
          end
        end
      end
      if (p < 0) begin
        r.status = 1'b1;
        break;
      end
      piv = lp_tab[p][q];
      for (int i = 0; i <= m; i++)
        for (int j = 0; j <= w; j++)
          if (i != p && j != q)
            lp_tab[i][j] = sub_clip(lp_tab[i][j], scale_div(lp_tab[p][j], lp_tab[i][q], piv));
      for (int i = 0; i <= m; i++) if (i != p) lp_tab[i][q] = 0;
      for (int j = 0; j <= w; j++) if (j != q) lp_tab[p][j] = scale_div(lp_tab[p][j], LP_ONE, piv);
      lp_tab[p][q] = LP_ONE;
    end
    corner = lp_tab[m][w];
    if (corner == LP_MIN) begin
      sat_seen = 1;
      r.objective = LP_MAX;
    end else begin
      r.objective = -corner;
    end
    r.saturated = sat_seen;
    return r;
  endfunction

  function automatic void apply_req(smp_pkg::in_req_t it);
    int m, n;
    m = rows_used();
    n = vars_used();
    case (it.action)
      smp_pkg::ACT_LOAD_A: begin
        if (it.row_index < m && it.col_index < n) lp_tab[it.row_index][it.col_index] = it.coefficient;
      end
      smp_pkg::ACT_LOAD_B: begin
        if (it.row_index < m) lp_tab[it.row_index][m + n] = it.coefficient;
      end
      smp_pkg::ACT_LOAD_C: begin
        if (it.col_index < n) lp_tab[m][it.col_index] = it.coefficient;
      end
      default: solve_q.push_back(run_solve());
    endcase
  endfunction

  task automatic send_req(logic [1:0] act, int r, int c, longint v);
    smp_pkg::in_req_t it;
    it.action = act;
    it.row_index = r[3:0];
    it.col_index = c[3:0];
    it.coefficient = v;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    apply_req(it);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (solve_q.size() == 0);
    repeat (30) @(negedge clk);
  endtask

  task automatic cfg_write(logic [smp_pkg::CFG_IDX_W-1:0] idx, logic [smp_pkg::SIZE_W-1:0] val);
    wait_idle();
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      smp_pkg::CFG_NUM_CONSTRAINTS: begin
        rows_reg = val;
        clear_tab();
      end
      smp_pkg::CFG_NUM_VARIABLES: begin
        vars_reg = val;
        clear_tab();
      end
      smp_pkg::CFG_PIVOT_RULE: dantzig = val[0];
      default: ;
    endcase
  endtask

  function automatic longint q_int(int k);
    return longint'(k) <<< 32;
  endfunction

  function automatic longint rand_val(int lo, int hi);
    longint v;
    v = q_int($urandom_range(0, hi - lo) + lo);
    if ($urandom_range(0, 3) == 0) v = v + (longint'($urandom_range(0, 65535)) <<< 16);
    return v;
  endfunction

  // result checker
  always @(posedge clk) begin
    smp_pkg::out_req_t e;
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (solve_q.size() == 0) begin
        $error("result with no solve pending");
        errors++;
      end else begin
        e = solve_q.pop_front();
        solves_done++;
        if (out_data.status) unbounded_seen++;
        if (out_data.saturated) sat_results++;
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.objective !== e.objective) begin
          $error("objective exp %h got %h", e.objective, out_data.objective);
          errors++;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (long_req) begin
      long_req = 0;
      hold = LONG_HOLD;
    end
    if (hold > 0) begin
      hold--;
      out_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold = $urandom_range(0, 9);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic test_reset_state();
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    send_req(smp_pkg::ACT_LOAD_C, 0, 0, LP_ONE);
    send_req(smp_pkg::ACT_LOAD_A, 0, 0, q_int(2));
    send_req(smp_pkg::ACT_LOAD_B, 0, 0, q_int(5));
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
  endtask

  task automatic test_extremes();
    cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, 5'd1);
    send_req(smp_pkg::ACT_LOAD_A, 15, 0, LP_MIN);
    send_req(smp_pkg::ACT_LOAD_C, 0, 15, LP_MIN);
    send_req(smp_pkg::ACT_LOAD_A, 0, 0, LP_ONE);
    send_req(smp_pkg::ACT_LOAD_B, 0, 9, LP_MAX);
    send_req(smp_pkg::ACT_LOAD_C, 0, 0, LP_MAX);
    send_req(smp_pkg::ACT_SOLVE, 15, 15, LP_MIN);
    cfg_write(smp_pkg::CFG_NUM_VARIABLES, 5'd1);
    send_req(smp_pkg::ACT_LOAD_C, 0, 0, q_int(3));
    send_req(smp_pkg::ACT_LOAD_A, 0, 0, -LP_ONE);
    send_req(smp_pkg::ACT_SOLVE, 0, 0, -1);
  endtask

  task automatic test_sizes_and_rules();
    cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, 5'd0);
    cfg_write(smp_pkg::CFG_NUM_VARIABLES, 5'd0);
    send_req(smp_pkg::ACT_LOAD_C, 0, 0, LP_ONE);
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, 5'd31);
    cfg_write(smp_pkg::CFG_NUM_VARIABLES, 5'd31);
    cfg_write(CFG_UNUSED, 5'd31);
    send_req(smp_pkg::ACT_LOAD_A, 15, 15, q_int(4));
    send_req(smp_pkg::ACT_LOAD_B, 15, 0, q_int(8));
    send_req(smp_pkg::ACT_LOAD_C, 0, 15, q_int(3));
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, 5'd2);
    cfg_write(smp_pkg::CFG_NUM_VARIABLES, 5'd3);
    for (int rule = 0; rule < 2; rule++) begin
      cfg_write(smp_pkg::CFG_PIVOT_RULE, rule[4:0]);
      if (rule == 1) begin
        cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, 5'd2);
      end
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 3; j++) send_req(smp_pkg::ACT_LOAD_A, i, j, q_int(1 + i + j));
      send_req(smp_pkg::ACT_LOAD_B, 0, 0, q_int(6));
      send_req(smp_pkg::ACT_LOAD_B, 1, 0, q_int(9));
      send_req(smp_pkg::ACT_LOAD_C, 0, 0, q_int(1));
      send_req(smp_pkg::ACT_LOAD_C, 0, 1, q_int(2));
      send_req(smp_pkg::ACT_LOAD_C, 0, 2, q_int(5));
      send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    long_req = 1;
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    for (int k = 0; k < 6; k++) send_req(smp_pkg::ACT_LOAD_C, 0, k % 3, rand_val(-5, 9));
    send_req(smp_pkg::ACT_SOLVE, 0, 0, 0);
    send_req(smp_pkg::ACT_LOAD_B, 0, 0, q_int(3));
    wait_idle();
  endtask

  task automatic test_random();
    int m, n, nloads, ep;
    ep = 0;
    while (sent < TARGET_REQS) begin
      if (sent > TARGET_REQS * 85 / 100) calm = 1;
      if (ep % 3 == 0) begin
        m = $urandom_range(1, 3);
        n = $urandom_range(1, 3);
        cfg_write(smp_pkg::CFG_NUM_CONSTRAINTS, m[4:0]);
        cfg_write(smp_pkg::CFG_NUM_VARIABLES, n[4:0]);
      end
      if (ep % 4 == 1) cfg_write(smp_pkg::CFG_PIVOT_RULE, 5'($urandom_range(0, 1)));
      if (ep % 10 == 7) begin
        wait_idle();
      end
      nloads = $urandom_range(6, 30);
      for (int k = 0; k < nloads; k++) begin
        case ($urandom_range(0, 9))
          0: send_req(2'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 15),
                      {$urandom, $urandom});
          1, 2, 3, 4: send_req(smp_pkg::ACT_LOAD_A, $urandom_range(0, m - 1),
                               $urandom_range(0, n - 1), rand_val(-3, 9));
          5, 6: send_req(smp_pkg::ACT_LOAD_B, $urandom_range(0, m - 1), 0, rand_val(0, 9));
          default: send_req(smp_pkg::ACT_LOAD_C, 0, $urandom_range(0, n - 1), rand_val(-5, 9));
        endcase
      end
      send_req(smp_pkg::ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
               {$urandom, $urandom});
      ep++;
    end
  endtask

  initial begin
    clear_tab();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_extremes();
    test_sizes_and_rules();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (100) @(negedge clk);
    $display("covered %0d requests, %0d solves (%0d unbounded, %0d saturated)",
             sent, solves_done, unbounded_seen, sat_results);
    $display("sizes 1x1 to 16x16, both pivot rules, long output stall and drain pause");
    if (errors == 0 && solve_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* simplex_lp_solver_unit.f */
rtl/smp_pkg.sv
rtl/smp_muldiv.sv
rtl/simplex_lp_solver_unit.sv
rtl/smp_chk.sv
dv/tb_simplex_lp_solver_unit.sv
